/* sv/aemd_pkg.sv */
// shared types and constants for the audio envelope motor drive
// no dependencies; imported by every module of the block except aemd_ram
package aemd_pkg;

	// configuration register widths
	localparam int WL_BITS    = 11;
	localparam int THR_BITS   = 15;
	localparam int FLIP_BITS  = 24;
	localparam int QUIET_BITS = 16;
	localparam int DUTY_BITS  = 8;
	localparam int CFG_DW     = 24;
	localparam int CFG_IW     = 3;

	// (threshold + 1) and its square
	localparam int THP_BITS = THR_BITS + 1;
	localparam int TSQ_BITS = 2 * THR_BITS + 1;

	// result queue
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [QUIET_BITS-1:0] QUIET_MAX = '1;
	localparam logic [FLIP_BITS-1:0]  SINCE_MAX = '1;

	// direction pin pairs, bit 0 is pin a, bit 1 is pin b
	localparam logic [1:0] PINS_FWD   = 2'b01;
	localparam logic [1:0] PINS_REV   = 2'b10;
	localparam logic [1:0] PINS_MOUTH = 2'b10;

	typedef enum logic [CFG_IW-1:0] {
		REG_WINDOW_LEN      = 3'd0,
		REG_BODY_THRESHOLD  = 3'd1,
		REG_MOUTH_THRESHOLD = 3'd2,
		REG_FLIP_INTERVAL   = 3'd3,
		REG_LOW_RUN_LIMIT   = 3'd4,
		REG_BODY_PWM        = 3'd5,
		REG_MOUTH_PWM       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic clr;
		logic wr;
		logic old_vld;
		logic upd;
	} lane_ctl_t;

	typedef struct packed {
		logic                 body_dir_a;
		logic                 body_dir_b;
		logic [DUTY_BITS-1:0] body_speed;
		logic                 mouth_dir_a;
		logic                 mouth_dir_b;
		logic [DUTY_BITS-1:0] mouth_speed;
	} result_t;

endpackage

/* sv/aemd_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// read returns the contents before a write to the same address in that cycle
module aemd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/aemd_lane.sv */
// one band lane: sample history, running sum of squares and threshold compare
// depends on aemd_pkg and aemd_ram
module aemd_lane
	import aemd_pkg::*;
#(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lane_ctl_t                           ctl,
	input  logic [$clog2(MAX_WINDOW)-1:0]       addr,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic [THR_BITS-1:0]                 threshold,
	input  logic [$clog2(MAX_WINDOW):0]         eff_w,
	output logic                                active
);

	localparam int AW  = $clog2(MAX_WINDOW);
	localparam int WLW = AW + 1;
	localparam int SQW = 2 * SAMPLE_BITS - 1;
	localparam int DW  = 2 * SAMPLE_BITS;
	localparam int EW  = 2 * SAMPLE_BITS - 1 + AW;
	localparam int LW  = TSQ_BITS + WLW;
	localparam int CW  = (EW > LW) ? EW : LW;

	logic [SAMPLE_BITS-1:0]        old_raw;
	logic signed [SAMPLE_BITS-1:0] new_s1;
	logic                          old_vld_s1;
	logic signed [SAMPLE_BITS-1:0] old_s1;
	logic signed [DW-1:0]          prod_new;
	logic signed [DW-1:0]          prod_old;
	logic [SQW-1:0]                sq_new_s2;
	logic [SQW-1:0]                sq_old_s2;
	logic signed [DW-1:0]          delta_s3;
	logic [EW-1:0]                 energy_q;
	logic [EW-1:0]                 energy_next;
	logic [THP_BITS-1:0]           thr_p1;
	logic [2*THP_BITS-1:0]         tsq_full;
	logic [TSQ_BITS-1:0]           tsq_q;
	logic [LW-1:0]                 lim_full;
	logic [LW-1:0]                 lim_q;
	logic                          active_s4;

	aemd_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (ctl.wr),
		.waddr(addr),
		.wdata(sample),
		.raddr(addr),
		.rdata(old_raw)
	);

	// slots never written since the last clear read as zero
	assign old_s1   = old_vld_s1 ? $signed(old_raw) : '0;
	assign prod_new = new_s1 * new_s1;
	assign prod_old = old_s1 * old_s1;

	assign energy_next = energy_q + EW'(delta_s3);

	// limit = (threshold + 1)^2 * window, registered through tsq_q and then lim_q after a write
	assign thr_p1   = THP_BITS'(threshold) + THP_BITS'(1);
	assign tsq_full = thr_p1 * thr_p1;
	assign lim_full = tsq_q * eff_w;

	always_ff @(posedge clk) begin
		new_s1     <= sample;
		old_vld_s1 <= ctl.old_vld;
		sq_new_s2  <= prod_new[SQW-1:0];
		sq_old_s2  <= prod_old[SQW-1:0];
		delta_s3   <= $signed({1'b0, sq_new_s2}) - $signed({1'b0, sq_old_s2});
		active_s4  <= CW'(energy_next) >= CW'(lim_q);
		tsq_q      <= tsq_full[TSQ_BITS-1:0];
		lim_q      <= lim_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
		end else if (ctl.clr) begin
			energy_q <= '0;
		end else if (ctl.upd) begin
			energy_q <= energy_next;
		end
	end

	assign active = active_s4;

endmodule

/* sv/aemd_merge.sv */
// merge stage: combines both lane decisions into pin levels and duties
// holds flip bit, quiet run and since-flip counters; depends on aemd_pkg
module aemd_merge
	import aemd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  logic                  body_on,
	input  logic                  mouth_on,
	input  logic [FLIP_BITS-1:0]  flip_interval,
	input  logic [QUIET_BITS-1:0] low_run_limit,
	input  logic [DUTY_BITS-1:0]  body_pwm,
	input  logic [DUTY_BITS-1:0]  mouth_pwm,
	output logic                  push,
	output result_t               res
);

	logic                  flip_q;
	logic [QUIET_BITS-1:0] quiet_q;
	logic [FLIP_BITS-1:0]  since_q;
	logic [3:0]            pins_q;

	logic                  flip_d;
	logic [QUIET_BITS-1:0] quiet_d;
	logic [QUIET_BITS-1:0] quiet_inc;
	logic [FLIP_BITS-1:0]  since_d;
	logic [FLIP_BITS-1:0]  since_inc;
	logic [3:0]            pins_d;
	logic [DUTY_BITS-1:0]  body_spd;
	logic [DUTY_BITS-1:0]  mouth_spd;

	always_comb begin
		since_inc = (since_q == SINCE_MAX) ? since_q : since_q + FLIP_BITS'(1);
		quiet_inc = (quiet_q == QUIET_MAX) ? quiet_q : quiet_q + QUIET_BITS'(1);
		flip_d    = flip_q;
		quiet_d   = quiet_q;
		since_d   = since_inc;
		pins_d    = pins_q;
		body_spd  = '0;
		mouth_spd = '0;
		if (body_on) begin
			pins_d[1:0] = flip_q ? PINS_REV : PINS_FWD;
			body_spd    = body_pwm;
			quiet_d     = '0;
		end else begin
			quiet_d = quiet_inc;
			// long quiet run, once the flip interval has also passed: reverse the body for the next active stretch
			if (quiet_inc > low_run_limit && since_inc >= flip_interval) begin
				flip_d  = ~flip_q;
				since_d = '0;
			end
		end
		if (mouth_on) begin
			pins_d[3:2] = PINS_MOUTH;
			mouth_spd   = mouth_pwm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q  <= 1'b0;
			quiet_q <= '0;
			since_q <= '0;
			pins_q  <= '0;
		end else if (vld) begin
			flip_q  <= flip_d;
			quiet_q <= quiet_d;
			since_q <= since_d;
			pins_q  <= pins_d;
		end
	end

	assign push            = vld;
	assign res.body_dir_a  = pins_d[0];
	assign res.body_dir_b  = pins_d[1];
	assign res.body_speed  = body_spd;
	assign res.mouth_dir_a = pins_d[2];
	assign res.mouth_dir_b = pins_d[3];
	assign res.mouth_speed = mouth_spd;

endmodule

/* sv/aemd_outq.sv */
// small result queue between the merge stage and the output channel
// depends on aemd_pkg; never overflows because the top level holds back credit
module aemd_outq
	import aemd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t wdata,
	input  logic    pop,
	output logic    rvalid,
	output result_t rdata
);

	result_t        entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

	assign rvalid = (count_q != '0);
	assign rdata  = entry_q[rd_ptr_q];

endmodule

/* sv/audio_envelope_motor_drive.sv */
// channel  | handshake             | beat contents
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_stall   | low_band_sample, high_band_sample
// out      | out_valid / out_stall | body_dir_a/b, body_speed, mouth_dir_a/b, mouth_speed
// cfg      | cfg_wr_en             | cfg_index, cfg_data
//
// the in channel takes one beat per cycle while in_stall is low
// two band lanes run in parallel, each with a history ram read and written in the
// accept cycle, then square, difference, accumulate-and-compare; the merge stage follows
// results wait in an eight-entry queue; in_stall rises once eight beats are in flight
// or waiting, so out_stall backs up into the input before the queue can overflow
// reset takes effect at once: no ram sweep, a fill count makes unwritten history read zero
module audio_envelope_motor_drive
	import aemd_pkg::*;
#(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] low_band_sample,
	input  logic signed [SAMPLE_BITS-1:0] high_band_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          body_dir_a,
	output logic                          body_dir_b,
	output logic [DUTY_BITS-1:0]          body_speed,
	output logic                          mouth_dir_a,
	output logic                          mouth_dir_b,
	output logic [DUTY_BITS-1:0]          mouth_speed,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IW-1:0]             cfg_index,
	input  logic [CFG_DW-1:0]             cfg_data
);

	localparam int AW  = $clog2(MAX_WINDOW);
	localparam int WLW = AW + 1;
	localparam logic [WLW-1:0] FILL_MAX = WLW'(MAX_WINDOW);

	logic [WL_BITS-1:0]    window_len_q;
	logic [THR_BITS-1:0]   body_thr_q;
	logic [THR_BITS-1:0]   mouth_thr_q;
	logic [FLIP_BITS-1:0]  flip_interval_q;
	logic [QUIET_BITS-1:0] low_run_limit_q;
	logic [DUTY_BITS-1:0]  body_pwm_q;
	logic [DUTY_BITS-1:0]  mouth_pwm_q;

	logic [AW-1:0]  pos_q;
	logic [WLW-1:0] fill_q;
	logic [WLW-1:0] pos_inc;
	logic [WLW-1:0] eff_w;
	logic [31:0]    wl_ext;
	logic           v_s1;
	logic           v_s2;
	logic           v_s3;
	logic           v_s4;
	logic [QAW:0]   cred_q;

	logic      in_fire;
	logic      out_fire;
	logic      win_clr;
	lane_ctl_t lane_ctl;
	logic      body_on;
	logic      mouth_on;
	logic      res_push;
	result_t   res;
	result_t   out_res;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign in_stall = (cred_q == (QAW+1)'(QDEPTH));
	assign win_clr  = cfg_wr_en && (reg_idx_t'(cfg_index) == REG_WINDOW_LEN);

	// window length of zero acts as one, above the history depth as the depth
	assign wl_ext = 32'(window_len_q);
	assign eff_w  = (window_len_q == '0) ? WLW'(1) :
		(wl_ext > 32'(MAX_WINDOW)) ? FILL_MAX : WLW'(wl_ext);
	assign pos_inc = WLW'({1'b0, pos_q}) + WLW'(1);

	assign lane_ctl.clr     = win_clr;
	assign lane_ctl.wr      = in_fire;
	assign lane_ctl.old_vld = (WLW'({1'b0, pos_q}) < fill_q);
	assign lane_ctl.upd     = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q    <= WL_BITS'(512);
			body_thr_q      <= THR_BITS'(1000);
			mouth_thr_q     <= THR_BITS'(1000);
			flip_interval_q <= FLIP_BITS'(44100);
			low_run_limit_q <= QUIET_BITS'(551);
			body_pwm_q      <= '1;
			mouth_pwm_q     <= '1;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WINDOW_LEN:      window_len_q    <= cfg_data[WL_BITS-1:0];
				REG_BODY_THRESHOLD:  body_thr_q      <= cfg_data[THR_BITS-1:0];
				REG_MOUTH_THRESHOLD: mouth_thr_q     <= cfg_data[THR_BITS-1:0];
				REG_FLIP_INTERVAL:   flip_interval_q <= cfg_data[FLIP_BITS-1:0];
				REG_LOW_RUN_LIMIT:   low_run_limit_q <= cfg_data[QUIET_BITS-1:0];
				REG_BODY_PWM:        body_pwm_q      <= cfg_data[DUTY_BITS-1:0];
				REG_MOUTH_PWM:       mouth_pwm_q     <= cfg_data[DUTY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			cred_q <= '0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (win_clr) begin
				pos_q  <= '0;
				fill_q <= '0;
			end else if (in_fire) begin
				pos_q  <= (pos_inc >= eff_w) ? '0 : pos_inc[AW-1:0];
				fill_q <= (fill_q == FILL_MAX) ? fill_q : fill_q + WLW'(1);
			end
			if (in_fire && !out_fire) begin
				cred_q <= cred_q + (QAW+1)'(1);
			end else if (out_fire && !in_fire) begin
				cred_q <= cred_q - (QAW+1)'(1);
			end
		end
	end

	aemd_lane #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_low (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.addr     (pos_q),
		.sample   (low_band_sample),
		.threshold(body_thr_q),
		.eff_w    (eff_w),
		.active   (body_on)
	);

	aemd_lane #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_high (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.addr     (pos_q),
		.sample   (high_band_sample),
		.threshold(mouth_thr_q),
		.eff_w    (eff_w),
		.active   (mouth_on)
	);

	aemd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld          (v_s4),
		.body_on      (body_on),
		.mouth_on     (mouth_on),
		.flip_interval(flip_interval_q),
		.low_run_limit(low_run_limit_q),
		.body_pwm     (body_pwm_q),
		.mouth_pwm    (mouth_pwm_q),
		.push         (res_push),
		.res          (res)
	);

	aemd_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.pop   (out_fire),
		.rvalid(out_valid),
		.rdata (out_res)
	);

	assign body_dir_a  = out_res.body_dir_a;
	assign body_dir_b  = out_res.body_dir_b;
	assign body_speed  = out_res.body_speed;
	assign mouth_dir_a = out_res.mouth_dir_a;
	assign mouth_dir_b = out_res.mouth_dir_b;
	assign mouth_speed = out_res.mouth_speed;

	// beats in flight plus queued never exceed the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cred_q <= (QAW+1)'(QDEPTH))
		else $error("credit count above queue depth");

	// a waiting result always holds a credit
	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cred_q != '0))
		else $error("result queued without credit");

	// write position stays inside the active window
	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		WLW'({1'b0, pos_q}) < eff_w)
		else $error("window position out of range");

	// a driven body motor always has opposite direction pins
	a_body_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (body_speed != '0)) |-> (body_dir_a != body_dir_b))
		else $error("body driven with equal direction pins");

endmodule
